FILE: rtl/core/tssq_pkg.sv
// ----------------------------------------------------------------------------
// tssq_pkg
// Shared widths, constants, register indexes and control structs for the
// test signal segment sequencer.
// ----------------------------------------------------------------------------
package tssq_pkg;

    // Payload widths
    localparam int SEG_W = 8;
    localparam int CNT_W = 16;
    localparam int BYTE_W = 8;

    // Period map geometry
    localparam int MAP_ENTRIES = 8;
    localparam int MAP_IDX_W = $clog2(MAP_ENTRIES) > 0 ? $clog2(MAP_ENTRIES) : 1;
    localparam int MAP_W = MAP_ENTRIES * BYTE_W;

    // Configuration port
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = MAP_W;
    localparam logic [CFG_IDX_W-1:0] CFG_PERIOD_MAP = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FREQ_CODE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LAST_SEGMENT = 2'd2;

    // Duration arithmetic
    localparam int unsigned DIV_UNIT = 12207;
    localparam int unsigned MUL_SCALE = 20000000;
    localparam int unsigned DUR_CAP = 52427;
    localparam int unsigned COUNT_CAP = 52428;

    // Numerator: 8-bit count times scale plus half divisor
    localparam int PROD_W = 33;
    // Divisor: DIV_UNIT times up to 256
    localparam int DEN_W = 22;
    localparam int DIV_CNT_W = $clog2(PROD_W);

    // Controller to datapath commands
    typedef struct packed {
        logic load;     // latch tick, form product and divisor
        logic prep;     // build numerator, clear remainder
        logic step;     // one restoring divide iteration
        logic commit;   // update state, load output register
    } tssq_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic out_free; // output register can take a result this cycle
    } tssq_status_t;

endpackage

FILE: rtl/core/tssq_ifs.sv
// ----------------------------------------------------------------------------
// tssq channel interfaces
// Valid/ready channels for tick items and result items.
// ----------------------------------------------------------------------------
interface tssq_in_if
    import tssq_pkg::*;
();
    logic valid;
    logic ready;
    logic restart;

    modport source (output valid, output restart, input ready);
    modport sink (input valid, input restart, output ready);
endinterface

interface tssq_out_if
    import tssq_pkg::*;
();
    logic             valid;
    logic             ready;
    logic [SEG_W-1:0] segment_index;
    logic [CNT_W-1:0] elapsed_ticks;
    logic [CNT_W-1:0] segment_duration;
    logic             segment_done;

    modport source (
        output valid, output segment_index, output elapsed_ticks,
        output segment_duration, output segment_done, input ready
    );
    modport sink (
        input valid, input segment_index, input elapsed_ticks,
        input segment_duration, input segment_done, output ready
    );
endinterface

FILE: rtl/core/tssq_ctrl.sv
// ----------------------------------------------------------------------------
// tssq_ctrl
// Sequencing state machine: accept a tick, run the divider, commit result.
// ----------------------------------------------------------------------------
module tssq_ctrl
    import tssq_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         in_valid,
    output logic         in_ready,
    input  tssq_status_t status,
    output tssq_cmd_t    cmd
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_PREP,
        S_DIV,
        S_COMMIT
    } state_t;

    state_t               state_reg;
    logic                 in_ready_reg;
    logic [DIV_CNT_W-1:0] iter_reg;

    // Command decode
    always_comb
    begin
        cmd.load = in_valid && in_ready_reg;
        cmd.prep = (state_reg == S_PREP);
        cmd.step = (state_reg == S_DIV);
        cmd.commit = (state_reg == S_COMMIT) && status.out_free;
    end

    assign in_ready = in_ready_reg;

    // State and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            in_ready_reg <= 1'b1;
            iter_reg <= '0;
        end
        else
        begin
            case (state_reg)
                S_IDLE:
                begin
                    if (in_valid && in_ready_reg)
                    begin
                        state_reg <= S_PREP;
                        in_ready_reg <= 1'b0;
                    end
                end
                S_PREP:
                begin
                    iter_reg <= '0;
                    state_reg <= S_DIV;
                end
                S_DIV:
                begin
                    // one quotient bit per cycle
                    if (iter_reg == DIV_CNT_W'(PROD_W - 1))
                        state_reg <= S_COMMIT;
                    else
                        iter_reg <= iter_reg + 1'b1;
                end
                S_COMMIT:
                begin
                    // hold until the output register is free
                    if (status.out_free)
                    begin
                        state_reg <= S_IDLE;
                        in_ready_reg <= 1'b1;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                    in_ready_reg <= 1'b1;
                end
            endcase
        end
    end

endmodule

FILE: rtl/core/tssq_dp.sv
// ----------------------------------------------------------------------------
// tssq_dp
// Datapath: config registers, segment state, duration product, restoring
// divider and the output register.
// ----------------------------------------------------------------------------
module tssq_dp
    import tssq_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  restart,
    input  tssq_cmd_t             cmd,
    output tssq_status_t          status,
    tssq_out_if.source            out_ch
);

    // Configuration
    logic [MAP_W-1:0] period_map_reg;
    logic [SEG_W-1:0] freq_code_reg;
    logic [SEG_W-1:0] last_segment_reg;

    // Segment state
    logic [CNT_W-1:0] elapsed_reg;
    logic [SEG_W-1:0] segment_reg;

    // Duration arithmetic
    logic             restart_reg;
    logic [PROD_W-1:0] prod_reg;
    logic [DEN_W-1:0]  den_reg;
    logic [PROD_W-1:0] quo_reg;
    logic [DEN_W-1:0]  rem_reg;

    // Output register
    logic             out_valid_reg;
    logic [SEG_W-1:0] out_seg_reg;
    logic [CNT_W-1:0] out_elapsed_reg;
    logic [CNT_W-1:0] out_dur_reg;
    logic             out_done_reg;

    logic [MAP_IDX_W-1:0] map_idx;
    logic [BYTE_W-1:0]    period_cnt;
    logic [SEG_W:0]       freq_plus;
    logic [PROD_W-1:0]    prod_next;
    logic [DEN_W-1:0]     den_next;
    logic [DEN_W:0]       trial;
    logic [DEN_W:0]       trial_diff;
    logic [CNT_W-1:0]     dur;
    logic [CNT_W:0]       elapsed_inc;
    logic [CNT_W-1:0]     elapsed_tick;
    logic [SEG_W:0]       seg_inc;
    logic                 advance;

    // Map lookup, segment capped at the last map entry
    always_comb
    begin
        if (segment_reg > SEG_W'(MAP_ENTRIES - 1))
            map_idx = MAP_IDX_W'(MAP_ENTRIES - 1);
        else
            map_idx = segment_reg[MAP_IDX_W-1:0];
        period_cnt = period_map_reg[BYTE_W*map_idx +: BYTE_W];
        freq_plus = {1'b0, freq_code_reg} + 1'b1;
        prod_next = PROD_W'(period_cnt) * PROD_W'(MUL_SCALE);
        den_next = DEN_W'(DIV_UNIT) * DEN_W'(freq_plus);
    end

    // Restoring divide step
    assign trial = {rem_reg, quo_reg[PROD_W-1]};
    assign trial_diff = trial - {1'b0, den_reg};

    // Result of the tick
    always_comb
    begin
        if (quo_reg > PROD_W'(DUR_CAP))
            dur = CNT_W'(DUR_CAP);
        else
            dur = quo_reg[CNT_W-1:0];
        elapsed_inc = {1'b0, elapsed_reg} + 1'b1;
        if (restart_reg)
            elapsed_tick = '0;
        else if (elapsed_inc > (CNT_W + 1)'(COUNT_CAP))
            elapsed_tick = CNT_W'(COUNT_CAP);
        else
            elapsed_tick = elapsed_inc[CNT_W-1:0];
        advance = (elapsed_tick >= dur);
        seg_inc = {1'b0, segment_reg} + 1'b1;
    end

    // Configuration writes; indexes past the list are dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            period_map_reg <= '0;
            freq_code_reg <= '0;
            last_segment_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_PERIOD_MAP:   period_map_reg <= cfg_data;
                CFG_FREQ_CODE:    freq_code_reg <= cfg_data[SEG_W-1:0];
                CFG_LAST_SEGMENT: last_segment_reg <= cfg_data[SEG_W-1:0];
                default:          ;
            endcase
        end
    end

    // Product, numerator and divider
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            restart_reg <= restart;
            prod_reg <= prod_next;
            den_reg <= den_next;
        end
        if (cmd.prep)
        begin
            quo_reg <= prod_reg + PROD_W'(den_reg >> 1);
            rem_reg <= '0;
        end
        else if (cmd.step)
        begin
            if (!trial_diff[DEN_W])
            begin
                rem_reg <= trial_diff[DEN_W-1:0];
                quo_reg <= {quo_reg[PROD_W-2:0], 1'b1};
            end
            else
            begin
                rem_reg <= trial[DEN_W-1:0];
                quo_reg <= {quo_reg[PROD_W-2:0], 1'b0};
            end
        end
    end

    // Segment state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            elapsed_reg <= '0;
            segment_reg <= '0;
        end
        else if (cmd.commit)
        begin
            if (advance)
            begin
                elapsed_reg <= '0;
                if (seg_inc > {1'b0, last_segment_reg})
                    segment_reg <= '0;
                else
                    segment_reg <= seg_inc[SEG_W-1:0];
            end
            else
            begin
                elapsed_reg <= elapsed_tick;
            end
        end
    end

    // Output register valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.commit)
            out_valid_reg <= 1'b1;
        else if (out_ch.ready)
            out_valid_reg <= 1'b0;
    end

    // Output register payload
    always_ff @(posedge clk)
    begin
        if (cmd.commit)
        begin
            out_dur_reg <= dur;
            out_done_reg <= advance;
            if (advance)
            begin
                out_elapsed_reg <= '0;
                if (seg_inc > {1'b0, last_segment_reg})
                    out_seg_reg <= '0;
                else
                    out_seg_reg <= seg_inc[SEG_W-1:0];
            end
            else
            begin
                out_elapsed_reg <= elapsed_tick;
                out_seg_reg <= segment_reg;
            end
        end
    end

    assign status.out_free = !out_valid_reg || out_ch.ready;

    assign out_ch.valid = out_valid_reg;
    assign out_ch.segment_index = out_seg_reg;
    assign out_ch.elapsed_ticks = out_elapsed_reg;
    assign out_ch.segment_duration = out_dur_reg;
    assign out_ch.segment_done = out_done_reg;

endmodule

FILE: rtl/core/test_signal_segment_sequencer_core.sv
// ----------------------------------------------------------------------------
// test_signal_segment_sequencer_core
// Segment sequencer for a bench test signal, one tick item per 8 ms.
// ----------------------------------------------------------------------------
// Each accepted tick yields one result. The tick is latched, and the period
// product and divisor are formed, at the accepting edge itself. After that
// the rounded numerator is built, the restoring divider produces one quotient
// bit per cycle, and the commit step updates the segment state and loads the
// output register. Input ready returns at the commit edge, so a tick is not
// accepted while the previous one is in flight. A new tick is accepted as
// soon as the previous result is in the output register, even if that result
// has not yet been taken. The commit step waits while the output register
// still holds an untaken result. Configuration writes take effect at once;
// the user must make them between ticks, as the block itself does not
// enforce it.
module test_signal_segment_sequencer_core
    import tssq_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    tssq_in_if.sink               in_ch,
    tssq_out_if.source            out_ch
);

    tssq_cmd_t    cmd;
    tssq_status_t status;
    logic         in_ready;

    assign in_ch.ready = in_ready;

    // Sequencing
    tssq_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_ch.valid),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    // Arithmetic and state
    tssq_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .restart   (in_ch.restart),
        .cmd       (cmd),
        .status    (status),
        .out_ch    (out_ch)
    );

`ifndef SYNTHESIS
    // one tick in flight at a time
    a_single_tick: assert property (@(posedge clk) disable iff (!rst_n)
        (in_ch.valid && in_ch.ready) |=> !in_ch.ready)
        else $error("tick accepted while another is in flight");

    // an advancing tick leaves the elapsed count cleared
    a_done_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (out_ch.valid && out_ch.segment_done) |-> (out_ch.elapsed_ticks == '0))
        else $error("segment advanced with nonzero elapsed count");

    // duration stays within its cap
    a_dur_cap: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid |-> (out_ch.segment_duration <= CNT_W'(DUR_CAP)))
        else $error("segment duration above cap");

    // commit only when the output register is free
    a_commit_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |-> (!out_ch.valid || out_ch.ready))
        else $error("result committed over an untaken result");
`endif

endmodule

FILE: tb/tssq_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tssq_checker
// Watches the tick, result and register channels of the segment sequencer,
// keeps its own copy of the segment state and compares every result.
// ----------------------------------------------------------------------------
module tssq_checker
    import tssq_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    tssq_in_if                    in_ch,
    tssq_out_if                   out_ch,
    output int                    fail_count,
    output int                    pending
);

    typedef struct packed {
        logic [SEG_W-1:0] segment_index;
        logic [CNT_W-1:0] elapsed_ticks;
        logic [CNT_W-1:0] segment_duration;
        logic             segment_done;
    } tick_result_t;

    // Shadow registers and segment state
    logic [MAP_W-1:0]  period_map;
    logic [BYTE_W-1:0] freq_code;
    logic [SEG_W-1:0]  last_segment;
    logic [CNT_W-1:0]  elapsed;
    logic [SEG_W-1:0]  segment;

    tick_result_t tick_results_q[$];

    always @(posedge clk or negedge rst_n)
    begin : track
        int unsigned     slot;
        int unsigned     count_next;
        int unsigned     seg_next;
        longint unsigned period;
        longint unsigned divisor;
        longint unsigned length;
        tick_result_t    want;
        tick_result_t    res;
        int              errs;

        if (!rst_n)
        begin
            period_map   = '0;
            freq_code    = '0;
            last_segment = '0;
            elapsed      = '0;
            segment      = '0;
            tick_results_q.delete();
            fail_count   <= 0;
            pending      <= 0;
        end
        else
        begin
            errs = 0;

            // Register writes; an index past the list is dropped
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_PERIOD_MAP:   period_map   = cfg_data;
                    CFG_FREQ_CODE:    freq_code    = cfg_data[BYTE_W-1:0];
                    CFG_LAST_SEGMENT: last_segment = cfg_data[SEG_W-1:0];
                    default: ;
                endcase
            end

            // Result transfer: match against the oldest outstanding tick
            if (out_ch.valid && out_ch.ready)
            begin
                if (tick_results_q.size() == 0)
                begin
                    errs++;
                    $error("result transfer with no tick outstanding");
                end
                else
                begin
                    want = tick_results_q.pop_front();
                    if (out_ch.segment_index !== want.segment_index)
                    begin
                        errs++;
                        $error("segment_index: expected %0d, actual %0d",
                               want.segment_index, out_ch.segment_index);
                    end
                    if (out_ch.elapsed_ticks !== want.elapsed_ticks)
                    begin
                        errs++;
                        $error("elapsed_ticks: expected %0d, actual %0d",
                               want.elapsed_ticks, out_ch.elapsed_ticks);
                    end
                    if (out_ch.segment_duration !== want.segment_duration)
                    begin
                        errs++;
                        $error("segment_duration: expected %0d, actual %0d",
                               want.segment_duration, out_ch.segment_duration);
                    end
                    if (out_ch.segment_done !== want.segment_done)
                    begin
                        errs++;
                        $error("segment_done: expected %0d, actual %0d",
                               want.segment_done, out_ch.segment_done);
                    end
                end
            end

            // Tick transfer: advance the shadow state and queue the result
            if (in_ch.valid && in_ch.ready)
            begin
                if (in_ch.restart)
                    count_next = 0;
                else
                begin
                    count_next = elapsed + 1;
                    if (count_next > COUNT_CAP)
                        count_next = COUNT_CAP;
                end

                // segments past the map share its last byte
                slot = segment;
                if (slot > MAP_ENTRIES - 1)
                    slot = MAP_ENTRIES - 1;
                period  = period_map[slot*BYTE_W +: BYTE_W];
                divisor = DIV_UNIT * (freq_code + 1);
                // round half up, then cap
                length  = (period * MUL_SCALE + divisor / 2) / divisor;
                if (length > DUR_CAP)
                    length = DUR_CAP;

                res.segment_done = 1'b0;
                if (count_next >= length)
                begin
                    // wide compare so a wrap past 255 lands on zero
                    seg_next = segment + 1;
                    segment  = (seg_next > last_segment) ? '0 : SEG_W'(seg_next);
                    count_next = 0;
                    res.segment_done = 1'b1;
                end
                elapsed = CNT_W'(count_next);

                res.segment_index    = segment;
                res.elapsed_ticks    = elapsed;
                res.segment_duration = CNT_W'(length);
                tick_results_q.push_back(res);
            end

            fail_count <= fail_count + errs;
            pending <= tick_results_q.size();
        end
    end

endmodule

FILE: tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives ticks and register writes into the segment sequencer with random
// gaps and back-pressure; the checker beside it predicts every result.
// ----------------------------------------------------------------------------
module testbench
    import tssq_pkg::*;
();

    // Index past the register list; writes there are dropped
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

    localparam int TICK_TARGET = 920;
    localparam int QUIET_FIRST = 400;
    localparam int QUIET_LAST  = 560;
    localparam int GAP_PCT     = 24;
    localparam int DRAIN_CYCLES = 50;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic                  quiet = 1'b0;
    int                    ticks_sent = 0;
    int                    fail_count;
    int                    pending;

    tssq_in_if  in_ch ();
    tssq_out_if out_ch ();

    test_signal_segment_sequencer_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_ch     (in_ch),
        .out_ch    (out_ch)
    );

    tssq_checker tick_check (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_ch      (in_ch),
        .out_ch     (out_ch),
        .fail_count (fail_count),
        .pending    (pending)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Result back-pressure, off during the quiet stretch
    always @(posedge clk)
        out_ch.ready <= quiet || ($urandom_range(99) >= GAP_PCT);

    // One tick transfer, with optional idle cycles ahead of it
    task automatic send_tick(input logic rs);
        if (!(ticks_sent >= QUIET_FIRST && ticks_sent < QUIET_LAST))
            while ($urandom_range(99) < GAP_PCT)
            begin
                in_ch.valid   <= 1'b0;
                in_ch.restart <= 1'($urandom_range(1));
                @(posedge clk);
            end
        quiet         <= ticks_sent >= QUIET_FIRST && ticks_sent < QUIET_LAST;
        in_ch.valid   <= 1'b1;
        in_ch.restart <= rs;
        do
            @(posedge clk);
        while (!in_ch.ready);
        ticks_sent++;
    endtask

    task automatic run_ticks(input int n, input int restart_pct);
        repeat (n)
            send_tick($urandom_range(99) < restart_pct);
    endtask

    // Stop sending and wait until every result has been taken
    task automatic settle();
        in_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
    endtask

    // Write all registers; byte fields get random upper data bits
    task automatic load_config(input logic [CFG_DATA_W-1:0] map,
                               input logic [BYTE_W-1:0] freq,
                               input logic [SEG_W-1:0] last,
                               input bit junk);
        logic [CFG_DATA_W-1:0] word;

        cfg_we    <= 1'b1;
        cfg_index <= CFG_PERIOD_MAP;
        cfg_data  <= map;
        @(posedge clk);
        word = {$urandom, $urandom};
        word[BYTE_W-1:0] = freq;
        cfg_index <= CFG_FREQ_CODE;
        cfg_data  <= word;
        @(posedge clk);
        word = {$urandom, $urandom};
        word[SEG_W-1:0] = last;
        cfg_index <= CFG_LAST_SEGMENT;
        cfg_data  <= word;
        @(posedge clk);
        if (junk)
        begin
            cfg_index <= CFG_UNUSED;
            cfg_data  <= {$urandom, $urandom};
            @(posedge clk);
        end
        cfg_we <= 1'b0;
    endtask

    initial
    begin : stimulus
        logic [CFG_DATA_W-1:0] map;
        logic [BYTE_W-1:0]     freq;
        logic [SEG_W-1:0]      last;
        int                    pick;
        int                    restart_pct;

        rst_n         = 1'b0;
        cfg_we        = 1'b0;
        cfg_index     = CFG_PERIOD_MAP;
        cfg_data      = '0;
        in_ch.valid   = 1'b0;
        in_ch.restart = 1'b0;
        out_ch.ready  = 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset registers: zero durations close segment 0 on every tick
        send_tick(1'b0);
        send_tick(1'b1);
        send_tick(1'b0);
        settle();

        // Full period at the lowest frequency saturates the duration
        load_config(64'hFF, 8'h00, 8'd1, 1'b1);
        send_tick(1'b0);
        send_tick(1'b1);
        send_tick(1'b0);
        settle();

        // All-ones map at the top frequency
        load_config('1, 8'hFF, 8'hFF, 1'b0);
        send_tick(1'b0);
        send_tick(1'b0);
        settle();

        // Short segment 1; segments 8 and 9 read the last map byte
        load_config(64'h100, 8'hFF, 8'd9, 1'b0);
        run_ticks(15, 0);
        settle();

        // Zero map, full index range: counter walks to 255 and wraps
        load_config('0, 8'($urandom), 8'hFF, 1'b1);
        run_ticks(270, 10);

        // Random register settings, mostly short segments
        while (ticks_sent < TICK_TARGET)
        begin
            settle();
            pick = $urandom_range(99);
            if (pick < 60)
                freq = 8'($urandom_range(255, 192));
            else if (pick < 75)
                freq = 8'hFF;
            else if (pick < 85)
                freq = 8'h00;
            else
                freq = 8'($urandom);

            for (int k = 0; k < MAP_ENTRIES; k++)
            begin
                pick = $urandom_range(99);
                if (pick < 45)
                    map[k*BYTE_W +: BYTE_W] = 8'($urandom_range(3));
                else if (pick < 75)
                    map[k*BYTE_W +: BYTE_W] = '0;
                else if (pick < 90)
                    map[k*BYTE_W +: BYTE_W] = 8'($urandom_range(12));
                else
                    map[k*BYTE_W +: BYTE_W] = 8'($urandom);
            end
            if ($urandom_range(9) == 0)
                map = {$urandom, $urandom};

            pick = $urandom_range(99);
            if (pick < 70)
                last = 8'($urandom_range(12));
            else if (pick < 80)
                last = 8'h00;
            else if (pick < 90)
                last = 8'hFF;
            else
                last = 8'($urandom);

            restart_pct = ($urandom_range(4) == 0) ? 50 : 8;
            load_config(map, freq, last, $urandom_range(3) == 0);
            run_ticks($urandom_range(70, 20), restart_pct);
        end

        settle();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0 && pending == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    // Hang guard
    initial
    begin
        #5_000_000;
        $display("FAILURE");
        $finish;
    end

endmodule
